@@ hw/rtl/i2cm16_pkg.sv @@
// shared types and constants for the 16-bit register i2c master
package i2cm16_pkg;

    localparam int DEV_ADDR_W   = 7;
    localparam int TIMEOUT_W    = 8;
    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd41;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 8'd250;

    localparam logic CFG_DEV_ADDR = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] ACT_WRITE     = 2'd0;
    localparam logic [1:0] ACT_READ_BYTE = 2'd1;

    typedef struct packed {
        logic        start_cmd;
        logic [1:0]  action;
        logic [15:0] reg_address;
        logic [7:0]  write_byte;
        logic        sda_sample;
    } t_in;

    typedef struct packed {
        logic        scl_level;
        logic        sda_pull_low;
        logic        busy_res;
        logic        done_res;
        logic        ack_error;
        logic [15:0] read_value;
    } t_out;

endpackage

@@ hw/rtl/i2cm16_front.sv @@
// input side: accepts ticks into a short queue
module i2cm16_front #(
    parameter int DEPTH = i2cm16_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  i2cm16_pkg::t_in      i_data,
    output logic                 o_valid,
    input  logic                 i_take,
    output i2cm16_pkg::t_in      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    i2cm16_pkg::t_in r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_stall = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign push = i_valid && !o_stall;
    assign pop  = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

@@ hw/rtl/i2cm16_back.sv @@
// bus sequencer: one queued tick per cycle, while the output is not stalled, into an output register
module i2cm16_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_take,
    input  i2cm16_pkg::t_in                       i_data,
    input  logic [i2cm16_pkg::DEV_ADDR_W-1:0]     i_dev_addr,
    input  logic [i2cm16_pkg::TIMEOUT_W-1:0]      i_timeout,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output i2cm16_pkg::t_out                      o_data
);
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_SEND  = 3'd2;
    localparam logic [2:0] PH_ACKW  = 3'd3;
    localparam logic [2:0] PH_READ  = 3'd4;
    localparam logic [2:0] PH_MACK  = 3'd5;
    localparam logic [2:0] PH_STOP  = 3'd6;
    localparam logic [2:0] PH_DONE  = 3'd7;

    logic [2:0]  r_phase, n_phase;
    logic [1:0]  r_tick, n_tick;
    logic [3:0]  r_bits, n_bits;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_wait, n_wait;
    logic [1:0]  r_act, n_act;
    logic [15:0] r_reg, n_reg;
    logic [7:0]  r_wbyte, n_wbyte;
    logic [15:0] r_gath, n_gath;
    logic        r_err, n_err;
    logic        r_ovalid;
    i2cm16_pkg::t_out r_out, n_out;
    logic        step, last;

    assign step    = i_valid && (!r_ovalid || !i_stall);
    assign o_take  = step;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign last    = (r_idx >= 3'd6) || (r_act == i2cm16_pkg::ACT_READ_BYTE);

    function automatic logic [7:0] pick_byte(input logic [2:0] idx,
                                             input logic [6:0] dev,
                                             input logic [15:0] ra,
                                             input logic [7:0] wb);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = {dev, 1'b0};
            3'd1:    b = ra[15:8];
            3'd2:    b = ra[7:0];
            3'd3:    b = wb;
            default: b = {dev, 1'b1};
        endcase
        return b;
    endfunction

    always_comb begin
        logic [2:0] ph;
        logic [1:0] tk;
        logic [3:0] bc;
        n_phase = r_phase; n_tick = r_tick; n_bits = r_bits; n_idx = r_idx;
        n_shift = r_shift; n_wait = r_wait; n_act = r_act; n_reg = r_reg;
        n_wbyte = r_wbyte; n_gath = r_gath; n_err = r_err;
        n_out = '0;
        n_out.scl_level = 1'b1;
        n_out.busy_res  = 1'b1;
        ph = r_phase;
        tk = r_tick;
        if (r_phase == PH_IDLE && i_data.start_cmd) begin
            n_act = i_data.action; n_reg = i_data.reg_address;
            n_wbyte = i_data.write_byte;
            n_gath = '0; n_err = 1'b0; n_idx = '0; n_wait = '0; n_shift = '0;
            ph = PH_START; tk = '0; n_bits = '0;
        end
        bc = n_bits;
        unique case (ph)
            PH_START: begin
                n_out.scl_level    = (tk == 2'd1) || (tk == 2'd2);
                n_out.sda_pull_low = (tk >= 2'd2);
                if (tk == 2'd3) begin
                    n_shift = pick_byte(n_idx, i_dev_addr, n_reg, n_wbyte);
                    n_phase = PH_SEND; n_tick = '0; n_bits = '0;
                end else begin
                    n_phase = ph; n_tick = tk + 2'd1;
                end
            end
            PH_SEND: begin
                n_out.sda_pull_low = !r_shift[7];
                n_out.scl_level    = tk[0];
                if (tk == 2'd0) begin
                    n_tick = 2'd1;
                end else begin
                    n_tick  = '0;
                    n_shift = {r_shift[6:0], 1'b0};
                    n_bits  = bc + 4'd1;
                    if (bc == 4'd7) begin
                        n_phase = PH_ACKW; n_bits = '0; n_wait = '0;
                    end
                end
            end
            PH_ACKW: begin
                if (tk == 2'd0) begin
                    n_out.scl_level = 1'b0;
                    n_tick = 2'd1;
                end else if (!i_data.sda_sample) begin
                    n_tick = '0; n_bits = '0;
                    priority case (r_idx)
                        3'd0, 3'd1: begin
                            n_idx = r_idx + 3'd1;
                            n_shift = pick_byte(n_idx, i_dev_addr, r_reg, r_wbyte);
                            n_phase = PH_SEND;
                        end
                        3'd2: begin
                            if (r_act == i2cm16_pkg::ACT_WRITE) begin
                                n_idx = 3'd3;
                                n_shift = r_wbyte;
                                n_phase = PH_SEND;
                            end else begin
                                n_idx = 3'd4;
                                n_phase = PH_START;
                            end
                        end
                        3'd4: begin
                            n_idx = 3'd5; n_shift = '0; n_phase = PH_READ;
                        end
                        default: n_phase = PH_STOP;
                    endcase
                end else if (r_wait >= i_timeout) begin
                    n_err = 1'b1;
                    n_phase = PH_STOP; n_tick = '0; n_bits = '0;
                end else begin
                    n_wait = r_wait + 8'd1;
                end
            end
            PH_READ: begin
                if (tk == 2'd0) begin
                    n_out.scl_level = 1'b0;
                    n_tick = 2'd1;
                end else begin
                    n_tick  = '0;
                    n_shift = {r_shift[6:0], i_data.sda_sample};
                    n_bits  = bc + 4'd1;
                    if (bc == 4'd7) begin
                        n_phase = PH_MACK; n_bits = '0;
                    end
                end
            end
            PH_MACK: begin
                n_out.sda_pull_low = !last;
                n_out.scl_level    = tk[0];
                if (tk == 2'd0) begin
                    n_tick = 2'd1;
                end else begin
                    n_gath = {r_gath[7:0], r_shift};
                    n_tick = '0; n_bits = '0;
                    if (last) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_idx = r_idx + 3'd1; n_shift = '0; n_phase = PH_READ;
                    end
                end
            end
            PH_STOP: begin
                n_out.scl_level    = (tk >= 2'd2);
                n_out.sda_pull_low = (tk == 2'd1) || (tk == 2'd2);
                if (tk == 2'd3) begin
                    n_phase = PH_DONE; n_tick = '0; n_bits = '0;
                end else begin
                    n_tick = tk + 2'd1;
                end
            end
            PH_DONE: begin
                n_out.busy_res   = 1'b0;
                n_out.done_res   = 1'b1;
                n_out.ack_error  = r_err;
                n_out.read_value = r_err ? 16'd0 : r_gath;
                n_phase = PH_IDLE; n_tick = '0; n_bits = '0;
            end
            default: begin
                n_out.busy_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out   <= n_out;
            r_shift <= n_shift; r_wait <= n_wait; r_act <= n_act;
            r_reg   <= n_reg;   r_wbyte <= n_wbyte; r_gath <= n_gath;
        end
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_tick <= '0; r_bits <= '0; r_idx <= '0;
            r_err <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (step) begin
                r_phase <= n_phase; r_tick <= n_tick; r_bits <= n_bits;
                r_idx <= n_idx; r_err <= n_err;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end
endmodule

@@ hw/rtl/i2c_master_reg16_access.sv @@
// i2c master for 16-bit register addresses: config registers, queue and sequencer
// Usage: each input transfer is one bus tick carrying a command request and the
// sampled SDA level; each tick yields exactly one output transfer with the SCL
// level, SDA pull-down, busy, done, ack_error and read_value for that tick.
// A command (start_cmd) is taken only when the sequencer is idle; write byte,
// read byte or read big-endian word. Every byte sent is followed by an ack wait
// that times out after ack_timeout+1 high samples and ends with STOP.
// Configuration: index 0 device_address, index 1 ack_timeout; write only
// while idle. The write channel is always ready.
// Throughput: one tick per cycle while the output is not stalled. An input
// transfer passes through the two-entry input queue and then the sequencer's
// output register; the sequencer state update is registered.
// Reset: synchronous, active low; the queue empties, the sequencer goes idle
// and the registers return to address 41 and timeout 250.
// Stall: while o_out_valid is held under stall the sequencer pauses and the
// queue fills; input stall rises when its two entries are full.
module i2c_master_reg16_access #(
    parameter int QUEUE_DEPTH = i2cm16_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  i2cm16_pkg::t_in                   i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output i2cm16_pkg::t_out                  o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [7:0]                        i_cfg_data
);
    logic [i2cm16_pkg::DEV_ADDR_W-1:0] r_dev_addr;
    logic [i2cm16_pkg::TIMEOUT_W-1:0]  r_timeout;
    logic q_valid, q_take;
    i2cm16_pkg::t_in q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= i2cm16_pkg::DEV_ADDR_RESET;
            r_timeout  <= i2cm16_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                i2cm16_pkg::CFG_DEV_ADDR: r_dev_addr <= i_cfg_data[6:0];
                i2cm16_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    i2cm16_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_stall(o_in_stall), .i_data(i_in_data),
        .o_valid(q_valid), .i_take(q_take), .o_data(q_data)
    );

    i2cm16_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_take(q_take), .i_data(q_data),
        .i_dev_addr(r_dev_addr), .i_timeout(r_timeout),
        .o_valid(o_out_valid), .i_stall(i_out_stall), .o_data(o_out_data)
    );
endmodule

@@ tb/tb_i2c_master_reg16_access.sv @@
// self-checking testbench for the 16-bit register i2c master
`timescale 1ns / 1ps

module tb_i2c_master_reg16_access;

    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_START, SEQ_SEND, SEQ_ACKW, SEQ_READ, SEQ_MACK, SEQ_STOP, SEQ_DONE
    } t_seq;

    class bus_tick_model;
        logic [6:0]  dev_addr;
        logic [7:0]  timeout;
        t_seq        seq;
        logic [2:0]  tick_cnt;
        logic [3:0]  bit_cnt;
        logic [2:0]  byte_idx;
        logic [7:0]  shift_reg;
        logic [7:0]  wait_cnt;
        logic [1:0]  cmd_action;
        logic [15:0] cmd_reg;
        logic [7:0]  cmd_data;
        logic [15:0] read_acc;
        logic        err_flag;
        i2cm16_pkg::t_out expected_ticks[$];
        int          errors;
        int          done_cnt;
        int          ack_err_cnt;
        int          word_cnt;

        function new();
            dev_addr = i2cm16_pkg::DEV_ADDR_RESET;
            timeout  = i2cm16_pkg::TIMEOUT_RESET;
            seq = SEQ_IDLE;
            tick_cnt = 0; bit_cnt = 0; byte_idx = 0; shift_reg = 0; wait_cnt = 0;
            cmd_action = 0; cmd_reg = 0; cmd_data = 0; read_acc = 0; err_flag = 0;
            errors = 0; done_cnt = 0; ack_err_cnt = 0; word_cnt = 0;
        endfunction

        function void go(t_seq s);
            seq = s;
            tick_cnt = 0;
            bit_cnt = 0;
        endfunction

        function void load_byte();
            case (byte_idx)
                3'd0:    shift_reg = {dev_addr, 1'b0};
                3'd1:    shift_reg = cmd_reg[15:8];
                3'd2:    shift_reg = cmd_reg[7:0];
                3'd3:    shift_reg = cmd_data;
                default: shift_reg = {dev_addr, 1'b1};
            endcase
            go(SEQ_SEND);
        endfunction

        function void acked();
            case (byte_idx)
                3'd0, 3'd1: begin
                    byte_idx++;
                    load_byte();
                end
                3'd2: begin
                    if (cmd_action == i2cm16_pkg::ACT_WRITE) begin
                        byte_idx = 3;
                        load_byte();
                    end else begin
                        byte_idx = 4;
                        go(SEQ_START);
                    end
                end
                3'd4: begin
                    byte_idx = 5;
                    shift_reg = 0;
                    go(SEQ_READ);
                end
                default: go(SEQ_STOP);
            endcase
        endfunction

        // notes an accepted input tick and queues the bus levels it causes
        function void take_tick(i2cm16_pkg::t_in x);
            i2cm16_pkg::t_out o;
            logic last;
            o = '0;
            o.scl_level = 1'b1;
            o.busy_res  = 1'b1;
            if (seq == SEQ_IDLE && x.start_cmd) begin
                cmd_action = x.action;
                cmd_reg    = x.reg_address;
                cmd_data   = x.write_byte;
                read_acc = 0; err_flag = 0; byte_idx = 0; wait_cnt = 0; shift_reg = 0;
                go(SEQ_START);
            end
            case (seq)
                SEQ_START: begin
                    o.scl_level    = (tick_cnt == 1 || tick_cnt == 2);
                    o.sda_pull_low = (tick_cnt >= 2);
                    if (tick_cnt >= 3) load_byte();
                    else tick_cnt++;
                end
                SEQ_SEND: begin
                    o.sda_pull_low = !shift_reg[7];
                    o.scl_level    = tick_cnt[0];
                    if (tick_cnt == 0) begin
                        tick_cnt = 1;
                    end else begin
                        tick_cnt = 0;
                        shift_reg = shift_reg << 1;
                        bit_cnt++;
                        if (bit_cnt >= 8) begin
                            go(SEQ_ACKW);
                            wait_cnt = 0;
                        end
                    end
                end
                SEQ_ACKW: begin
                    if (tick_cnt == 0) begin
                        o.scl_level = 1'b0;
                        tick_cnt = 1;
                    end else if (!x.sda_sample) begin
                        acked();
                    end else if (wait_cnt >= timeout) begin
                        err_flag = 1;
                        go(SEQ_STOP);
                    end else begin
                        wait_cnt++;
                    end
                end
                SEQ_READ: begin
                    if (tick_cnt == 0) begin
                        o.scl_level = 1'b0;
                        tick_cnt = 1;
                    end else begin
                        tick_cnt = 0;
                        shift_reg = {shift_reg[6:0], x.sda_sample};
                        bit_cnt++;
                        if (bit_cnt >= 8) go(SEQ_MACK);
                    end
                end
                SEQ_MACK: begin
                    last = (byte_idx >= 6) || (cmd_action == i2cm16_pkg::ACT_READ_BYTE);
                    o.sda_pull_low = !last;
                    o.scl_level    = tick_cnt[0];
                    if (tick_cnt == 0) begin
                        tick_cnt = 1;
                    end else begin
                        read_acc = {read_acc[7:0], shift_reg};
                        if (last) begin
                            go(SEQ_STOP);
                        end else begin
                            byte_idx = byte_idx + 1;
                            shift_reg = 0;
                            go(SEQ_READ);
                        end
                    end
                end
                SEQ_STOP: begin
                    o.scl_level    = (tick_cnt >= 2);
                    o.sda_pull_low = (tick_cnt == 1 || tick_cnt == 2);
                    if (tick_cnt >= 3) go(SEQ_DONE);
                    else tick_cnt++;
                end
                SEQ_DONE: begin
                    o.busy_res   = 1'b0;
                    o.done_res   = 1'b1;
                    o.ack_error  = err_flag;
                    o.read_value = err_flag ? 16'd0 : read_acc;
                    done_cnt++;
                    if (err_flag) ack_err_cnt++;
                    if (!err_flag && cmd_action[1]) word_cnt++;
                    go(SEQ_IDLE);
                end
                default: o.busy_res = 1'b0;
            endcase
            expected_ticks.push_back(o);
        endfunction

        function void check_tick(i2cm16_pkg::t_out a);
            i2cm16_pkg::t_out e;
            if (expected_ticks.size() == 0) begin
                $display("%0t: output transfer with nothing expected, actual %h", $time, a);
                errors++;
                return;
            end
            e = expected_ticks.pop_front();
            if (a.scl_level !== e.scl_level) begin
                $display("%0t: scl_level expected %b actual %b", $time, e.scl_level,
                         a.scl_level);
                errors++;
            end
            if (a.sda_pull_low !== e.sda_pull_low) begin
                $display("%0t: sda_pull_low expected %b actual %b", $time, e.sda_pull_low,
                         a.sda_pull_low);
                errors++;
            end
            if (a.busy_res !== e.busy_res) begin
                $display("%0t: busy_res expected %b actual %b", $time, e.busy_res,
                         a.busy_res);
                errors++;
            end
            if (a.done_res !== e.done_res) begin
                $display("%0t: done_res expected %b actual %b", $time, e.done_res,
                         a.done_res);
                errors++;
            end
            if (a.ack_error !== e.ack_error) begin
                $display("%0t: ack_error expected %b actual %b", $time, e.ack_error,
                         a.ack_error);
                errors++;
            end
            if (a.read_value !== e.read_value) begin
                $display("%0t: read_value expected %h actual %h", $time, e.read_value,
                         a.read_value);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_stall;
    i2cm16_pkg::t_in  in_data;
    logic        o_out_valid;
    logic        out_stall;
    i2cm16_pkg::t_out o_out_data;
    logic        cfg_valid;
    logic        o_cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    bus_tick_model model;
    bit          calm;
    bit          hold_long_req;
    int          ack_high_pct;
    int          idle_cycles;
    int          ticks_sent;

    i2c_master_reg16_access dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) model.check_tick(o_out_data);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                    || (cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 3000) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("tb_i2c_master_reg16_access: done, errors");
                $finish;
            end
        end
    end

    // receiver side stalls
    initial begin
        out_stall = 1'b0;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_long_req) begin
                out_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                out_stall <= 1'b0;
                hold_long_req = 0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // random tick shaped by where the sequencer is, so acks mostly come back low
    function automatic i2cm16_pkg::t_in make_tick();
        i2cm16_pkg::t_in t;
        t.reg_address = 16'($urandom);
        t.write_byte  = 8'($urandom);
        t.action      = 2'($urandom_range(0, 3));
        if (model.seq == SEQ_IDLE) t.start_cmd = ($urandom_range(0, 3) != 0);
        else t.start_cmd = ($urandom_range(0, 9) == 0);
        if (model.seq == SEQ_ACKW) t.sda_sample = ($urandom_range(0, 99) < ack_high_pct);
        else t.sda_sample = 1'($urandom_range(0, 1));
        return t;
    endfunction

    task automatic send_tick(i2cm16_pkg::t_in t);
        in_valid <= 1'b1;
        in_data  <= t;
        do @(posedge i_clk); while (o_in_stall);
        model.take_tick(t);
        ticks_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (model.expected_ticks.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == i2cm16_pkg::CFG_DEV_ADDR) model.dev_addr = val[6:0];
        else model.timeout = val;
        @(posedge i_clk);
    endtask

    task automatic random_ticks(int n);
        repeat (n) send_tick(make_tick());
    endtask

    initial begin
        i2cm16_pkg::t_in t;
        model = new();
        calm = 0;
        hold_long_req = 0;
        ack_high_pct = 3;
        idle_cycles = 0;
        ticks_sent = 0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = i2cm16_pkg::CFG_DEV_ADDR;
        cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: write with all-ones fields, then commands arriving while busy
        t = '0;
        t.start_cmd = 1'b1;
        t.action = i2cm16_pkg::ACT_WRITE;
        t.reg_address = 16'hffff;
        t.write_byte = 8'hff;
        send_tick(t);
        for (int i = 0; i < 23; i++) begin
            t = '0;
            t.start_cmd = 1'b1;
            t.action = 2'd3;
            t.reg_address = (i % 2) ? 16'hffff : 16'h0000;
            send_tick(t);
        end
        random_ticks(240);
        drain();

        // tiny timeout, address zero, long output hold-off
        write_cfg(i2cm16_pkg::CFG_DEV_ADDR, 8'd0);
        write_cfg(i2cm16_pkg::CFG_TIMEOUT, 8'd1);
        ack_high_pct = 40;
        random_ticks(60);
        hold_long_req = 1;
        random_ticks(200);
        drain();

        write_cfg(i2cm16_pkg::CFG_DEV_ADDR, 8'd127);
        write_cfg(i2cm16_pkg::CFG_TIMEOUT, 8'd255);
        ack_high_pct = 10;
        random_ticks(260);
        drain();

        // final stretch with no idling
        write_cfg(i2cm16_pkg::CFG_DEV_ADDR, 8'($urandom_range(0, 127)));
        write_cfg(i2cm16_pkg::CFG_TIMEOUT, 8'($urandom_range(2, 6)));
        ack_high_pct = 35;
        calm = 1;
        random_ticks(260);
        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d ticks, %0d transactions (%0d ack timeouts, %0d word reads)",
                 ticks_sent, model.done_cnt, model.ack_err_cnt, model.word_cnt);
        $display("across four address/timeout settings with stalls on both sides");
        if (model.errors == 0 && model.expected_ticks.size() == 0) begin
            $display("tb_i2c_master_reg16_access: done, clean");
        end else begin
            $display("tb_i2c_master_reg16_access: done, errors");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/i2cm16_pkg.sv
hw/rtl/i2cm16_front.sv
hw/rtl/i2cm16_back.sv
hw/rtl/i2c_master_reg16_access.sv
tb/tb_i2c_master_reg16_access.sv
